>>> design/hrsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrsp_pkg
// Shared types, codes and character helpers for the HTTP response parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

    localparam int LENGTH_BITS = 32;
    localparam int STATUS_BITS = 16;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX  = '1;
    localparam logic [STATUS_BITS-1:0] STAT_MAX = '1;

    localparam int LEN_ACC_BITS  = LENGTH_BITS + 5;
    localparam int STAT_ACC_BITS = STATUS_BITS + 5;

    // Configuration port
    localparam int                 ADDR_BITS     = 3;
    localparam logic [0:0]         REG_THRESHOLD = 1'b0;
    localparam logic [STATUS_BITS-1:0] THRESHOLD_RESET = STATUS_BITS'(500);

    // Input actions
    localparam logic [1:0] ACT_BYTE = 2'd0;
    localparam logic [1:0] ACT_EOF  = 2'd1;
    localparam logic [1:0] ACT_NEW  = 2'd2;

    // Parser modes
    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_WAIT   = 3'd1;
    localparam logic [2:0] M_HEAD   = 3'd2;
    localparam logic [2:0] M_BODY   = 3'd3;
    localparam logic [2:0] M_CLOSED = 3'd4;
    localparam logic [2:0] M_BROKEN = 3'd5;

    // Line phases: status line
    localparam logic [2:0] S_PREFIX = 3'd0;
    localparam logic [2:0] S_MINOR1 = 3'd1;
    localparam logic [2:0] S_MINOR  = 3'd2;
    localparam logic [2:0] S_GAP    = 3'd3;
    localparam logic [2:0] S_STATUS = 3'd4;
    localparam logic [2:0] S_DONE   = 3'd5;
    localparam logic [2:0] S_FAIL   = 3'd6;

    // Line phases: header line
    localparam logic [2:0] H_START   = 3'd0;
    localparam logic [2:0] H_PREFIX  = 3'd1;
    localparam logic [2:0] H_OTHER   = 3'd2;
    localparam logic [2:0] H_VAL_WS  = 3'd3;
    localparam logic [2:0] H_ZERO    = 3'd4;
    localparam logic [2:0] H_HEX1    = 3'd5;
    localparam logic [2:0] H_VAL     = 3'd6;
    localparam logic [2:0] H_VAL_END = 3'd7;

    // Number bases of the length value
    localparam logic [1:0] BASE_DEC = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_HEX = 2'd2;

    localparam logic [4:0] STATUS_PREFIX_LEN = 5'd7;
    localparam logic [4:0] LENGTH_PREFIX_LEN = 5'd16;
    localparam logic [4:0] DIGIT_NONE        = 5'd16;

    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] data_byte;
    } item_t;

    // Output stream data word, last field in the lowest bits
    typedef struct packed {
        logic [1:0]             pad;
        logic                   server_overload;
        logic                   has_length;
        logic [LENGTH_BITS-1:0] content_length;
        logic                   status_valid;
        logic [STATUS_BITS-1:0] status_code;
        logic [7:0]             body_data;
        logic [2:0]             parse_state;
    } tdata_t;

    typedef struct packed {
        tdata_t data;
        logic   body_valid;
        logic   response_done;
    } res_t;

    function automatic logic [7:0] status_char(input logic [2:0] idx);
        logic [7:0] ch;
        case (idx)
            3'd0:    ch = "H";
            3'd1:    ch = "T";
            3'd2:    ch = "T";
            3'd3:    ch = "P";
            3'd4:    ch = "/";
            3'd5:    ch = "1";
            3'd6:    ch = ".";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [7:0] length_char(input logic [3:0] idx);
        logic [7:0] ch;
        case (idx)
            4'd0:    ch = "c";
            4'd1:    ch = "o";
            4'd2:    ch = "n";
            4'd3:    ch = "t";
            4'd4:    ch = "e";
            4'd5:    ch = "n";
            4'd6:    ch = "t";
            4'd7:    ch = "-";
            4'd8:    ch = "l";
            4'd9:    ch = "e";
            4'd10:   ch = "n";
            4'd11:   ch = "g";
            4'd12:   ch = "t";
            4'd13:   ch = "h";
            4'd14:   ch = ":";
            default: ch = " ";
        endcase
        return ch;
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    function automatic logic [4:0] digit_value(input logic [7:0] c);
        logic [4:0] d;
        if (c inside {["0":"9"]})
            d = 5'(c - "0");
        else if (c inside {["a":"f"]})
            d = 5'(c - "a" + 8'd10);
        else if (c inside {["A":"F"]})
            d = 5'(c - "A" + 8'd10);
        else
            d = DIGIT_NONE;
        return d;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c inside {["A":"Z"]}) ? c + 8'd32 : c;
    endfunction

    function automatic logic [4:0] radix_of(input logic [1:0] base);
        logic [4:0] r;
        case (base)
            BASE_OCT: r = 5'd8;
            BASE_HEX: r = 5'd16;
            default:  r = 5'd10;
        endcase
        return r;
    endfunction

    // Phase after a lone CR is fed as an ordinary whitespace character
    function automatic logic [2:0] feed_cr(input logic status_line, input logic [2:0] ph);
        logic [2:0] n;
        n = ph;
        if (status_line) begin
            case (ph)
                S_PREFIX: n = S_FAIL;
                S_MINOR1: n = S_FAIL;
                S_MINOR:  n = S_GAP;
                S_STATUS: n = S_DONE;
                default:  n = ph;
            endcase
        end
        else begin
            case (ph)
                H_START:  n = H_OTHER;
                H_PREFIX: n = H_OTHER;
                H_ZERO:   n = H_VAL_END;
                H_HEX1:   n = H_VAL_END;
                H_VAL:    n = H_VAL_END;
                default:  n = ph;
            endcase
        end
        return n;
    endfunction

    // v * radix + d, saturating at all ones
    function automatic logic [LENGTH_BITS-1:0] mac_len(input logic [LENGTH_BITS-1:0] v,
                                                      input logic [1:0] base,
                                                      input logic [3:0] d);
        logic [LEN_ACC_BITS-1:0] acc;
        case (base)
            BASE_HEX: acc = LEN_ACC_BITS'(v) << 4;
            BASE_OCT: acc = LEN_ACC_BITS'(v) << 3;
            default:  acc = (LEN_ACC_BITS'(v) << 3) + (LEN_ACC_BITS'(v) << 1);
        endcase
        acc = acc + LEN_ACC_BITS'(d);
        return (acc > LEN_ACC_BITS'(LEN_MAX)) ? LEN_MAX : acc[LENGTH_BITS-1:0];
    endfunction

    function automatic logic [STATUS_BITS-1:0] mac_stat(input logic [STATUS_BITS-1:0] v,
                                                       input logic [3:0] d);
        logic [STAT_ACC_BITS-1:0] acc;
        acc = (STAT_ACC_BITS'(v) << 3) + (STAT_ACC_BITS'(v) << 1) + STAT_ACC_BITS'(d);
        return (acc > STAT_ACC_BITS'(STAT_MAX)) ? STAT_MAX : acc[STATUS_BITS-1:0];
    endfunction

endpackage
`default_nettype wire

>>> design/http_response_stream_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// http_response_stream_parser
// Byte-at-a-time HTTP/1.x response header parser with body pass-through.
// ----------------------------------------------------------------------------
// Path: a word accepted on the slave side passes the input register, then
//   the result register, before it shows on the master side.
// Throughput: one word per cycle unless the master side stalls; the parser
//   step is a single pass through the state update logic between the two registers.
// Reset: rst_n is asynchronous, active low; the parser comes up idle with
//   every count cleared and the overload threshold at 500.
// ----------------------------------------------------------------------------
module http_response_stream_parser
(
    input  wire                             clk,
    input  wire                             rst_n,
    // Slave side
    input  wire                             s_tvalid,
    output logic                            s_tready,
    input  wire  [7:0]                      s_tdata,   // [7:0] data_byte
    input  wire  [1:0]                      s_tuser,   // [1:0] action
    // Master side
    output logic                            m_tvalid,
    input  wire                             m_tready,
    output logic [63:0]                     m_tdata,   // [2:0] parse_state,
                                                       // [10:3] body_data,
                                                       // [26:11] status_code,
                                                       // [27] status_valid,
                                                       // [59:28] content_length,
                                                       // [60] has_length,
                                                       // [61] server_overload
    output logic [0:0]                      m_tuser,   // [0] body_valid
    output logic                            m_tlast,   // response_done
    // Configuration
    input  wire                             psel,
    input  wire                             penable,
    input  wire                             pwrite,
    input  wire  [hrsp_pkg::ADDR_BITS-1:0]  paddr,
    input  wire  [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic                             in_vld_reg, in_vld_next;
    hrsp_pkg::item_t                  in_item_reg, in_item_next;
    logic                             out_vld_reg, out_vld_next;
    hrsp_pkg::res_t                   out_res_reg, out_res_next;

    logic                             s_fire;
    logic                             advance;
    logic [hrsp_pkg::STATUS_BITS-1:0] threshold;
    hrsp_pkg::res_t                   step_res;

    // Advance the held word whenever the result register is free or
    // being drained this cycle; take a new word whenever the input
    // register empties at the same edge.
    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    hrsp_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .threshold (threshold)
    );

    // The parser state moves only when a word advances into the result
    // register, so a stall on the master side freezes it.
    hrsp_parse u_parse
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (in_item_reg),
        .threshold (threshold),
        .res       (step_res)
    );

    always_comb
    begin
        in_vld_next  = in_vld_reg && !advance;
        in_item_next = in_item_reg;
        if (s_fire)
        begin
            in_vld_next            = 1'b1;
            in_item_next.action    = s_tuser;
            in_item_next.data_byte = s_tdata;
        end

        out_vld_next = out_vld_reg && !m_tready;
        out_res_next = out_res_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
            out_res_next = step_res;
        end
    end

    // Control: valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_res_reg <= out_res_next;
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = out_res_reg.data;
    assign m_tuser[0] = out_res_reg.body_valid;
    assign m_tlast    = out_res_reg.response_done;

endmodule
`default_nettype wire

>>> design/hrsp_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrsp_cfg
// Register port holding the overload status threshold.
// ----------------------------------------------------------------------------
module hrsp_cfg
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [hrsp_pkg::ADDR_BITS-1:0]      paddr,
    input  wire  [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic [hrsp_pkg::STATUS_BITS-1:0]    threshold
);

    logic [hrsp_pkg::STATUS_BITS-1:0] thr_reg;
    logic [hrsp_pkg::STATUS_BITS-1:0] thr_next;
    logic                             wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr[2] == hrsp_pkg::REG_THRESHOLD);

    always_comb
    begin
        thr_next = thr_reg;
        if (wr_hit)
        begin
            thr_next = pwdata[hrsp_pkg::STATUS_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= hrsp_pkg::THRESHOLD_RESET;
        end
        else
        begin
            thr_reg <= thr_next;
        end
    end

    assign prdata    = (paddr[2] == hrsp_pkg::REG_THRESHOLD) ? 32'(thr_reg) : 32'd0;
    assign threshold = thr_reg;

endmodule
`default_nettype wire

>>> design/hrsp_parse.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrsp_parse
// Parser state and the one-byte step that updates it and forms the result.
// ----------------------------------------------------------------------------
module hrsp_parse
(
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 step,
    input  wire  hrsp_pkg::item_t               item,
    input  wire  [hrsp_pkg::STATUS_BITS-1:0]    threshold,
    output hrsp_pkg::res_t                      res
);

    logic [2:0]                         mode_reg,  mode_next;
    logic [2:0]                         phase_reg, phase_next;
    logic [4:0]                         pidx_reg,  pidx_next;
    logic                               cr_reg,    cr_next;
    logic [hrsp_pkg::STATUS_BITS-1:0]   stat_reg,  stat_next;
    logic [hrsp_pkg::LENGTH_BITS-1:0]   len_reg,   len_next;
    logic [1:0]                         base_reg,  base_next;
    logic                               seen_reg,  seen_next;
    logic [hrsp_pkg::LENGTH_BITS-1:0]   cnt_reg,   cnt_next;
    logic [hrsp_pkg::LENGTH_BITS-1:0]   clen_reg,  clen_next;
    logic                               sok_reg,   sok_next;

    logic [7:0] c;
    logic [4:0] dv;
    logic [2:0] ph_a;
    logic       feed;
    logic       body_valid;
    logic       done;

    assign c  = item.data_byte;
    assign dv = hrsp_pkg::digit_value(c);

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        pidx_next  = pidx_reg;
        cr_next    = cr_reg;
        stat_next  = stat_reg;
        len_next   = len_reg;
        base_next  = base_reg;
        seen_next  = seen_reg;
        cnt_next   = cnt_reg;
        clen_next  = clen_reg;
        sok_next   = sok_reg;
        ph_a       = phase_reg;
        feed       = 1'b0;
        body_valid = 1'b0;
        done       = 1'b0;

        if (step)
        begin
            case (item.action)
                hrsp_pkg::ACT_BYTE:
                begin
                    if (mode_reg == hrsp_pkg::M_WAIT || mode_reg == hrsp_pkg::M_HEAD)
                    begin
                        feed = 1'b1;
                        if (cr_reg)
                        begin
                            cr_next = 1'b0;
                            if (c == hrsp_pkg::CHAR_LF)
                            begin
                                // end of line: commit what the line carried
                                feed = 1'b0;
                                if (mode_reg == hrsp_pkg::M_WAIT)
                                begin
                                    if (phase_reg == hrsp_pkg::S_STATUS ||
                                        phase_reg == hrsp_pkg::S_DONE)
                                    begin
                                        sok_next  = 1'b1;
                                        mode_next = hrsp_pkg::M_HEAD;
                                    end
                                    else
                                    begin
                                        mode_next = hrsp_pkg::M_BROKEN;
                                    end
                                end
                                else if (phase_reg == hrsp_pkg::H_START)
                                begin
                                    mode_next = hrsp_pkg::M_BODY;
                                    cnt_next  = '0;
                                    if (seen_reg && clen_reg == '0)
                                    begin
                                        mode_next = hrsp_pkg::M_IDLE;
                                        done      = 1'b1;
                                    end
                                end
                                else if (phase_reg >= hrsp_pkg::H_VAL_WS)
                                begin
                                    clen_next = len_reg;
                                    seen_next = 1'b1;
                                end
                                phase_next = hrsp_pkg::H_START;
                                pidx_next  = '0;
                                base_next  = hrsp_pkg::BASE_DEC;
                            end
                            else
                            begin
                                ph_a = hrsp_pkg::feed_cr(mode_reg == hrsp_pkg::M_WAIT,
                                                         phase_reg);
                            end
                        end

                        if (feed)
                        begin
                            phase_next = ph_a;
                            if (c == hrsp_pkg::CHAR_CR)
                            begin
                                cr_next = 1'b1;
                            end
                            else if (mode_reg == hrsp_pkg::M_WAIT)
                            begin
                                case (ph_a)
                                    hrsp_pkg::S_PREFIX:
                                    begin
                                        if (pidx_reg < hrsp_pkg::STATUS_PREFIX_LEN &&
                                            c == hrsp_pkg::status_char(pidx_reg[2:0]))
                                        begin
                                            pidx_next = pidx_reg + 5'd1;
                                            if (pidx_next == hrsp_pkg::STATUS_PREFIX_LEN)
                                            begin
                                                phase_next = hrsp_pkg::S_MINOR1;
                                            end
                                        end
                                        else
                                        begin
                                            phase_next = hrsp_pkg::S_FAIL;
                                        end
                                    end
                                    hrsp_pkg::S_MINOR1:
                                    begin
                                        phase_next = hrsp_pkg::is_digit(c) ?
                                                     hrsp_pkg::S_MINOR : hrsp_pkg::S_FAIL;
                                    end
                                    hrsp_pkg::S_MINOR:
                                    begin
                                        if (!hrsp_pkg::is_digit(c))
                                        begin
                                            phase_next = hrsp_pkg::is_space(c) ?
                                                         hrsp_pkg::S_GAP : hrsp_pkg::S_FAIL;
                                        end
                                    end
                                    hrsp_pkg::S_GAP:
                                    begin
                                        if (hrsp_pkg::is_digit(c))
                                        begin
                                            phase_next = hrsp_pkg::S_STATUS;
                                            stat_next  = hrsp_pkg::STATUS_BITS'(c[3:0]);
                                        end
                                        else if (!hrsp_pkg::is_space(c))
                                        begin
                                            phase_next = hrsp_pkg::S_FAIL;
                                        end
                                    end
                                    hrsp_pkg::S_STATUS:
                                    begin
                                        if (hrsp_pkg::is_digit(c))
                                        begin
                                            stat_next = hrsp_pkg::mac_stat(stat_reg, c[3:0]);
                                        end
                                        else
                                        begin
                                            phase_next = hrsp_pkg::S_DONE;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            else
                            begin
                                case (ph_a)
                                    hrsp_pkg::H_START,
                                    hrsp_pkg::H_PREFIX:
                                    begin
                                        if (pidx_reg < hrsp_pkg::LENGTH_PREFIX_LEN &&
                                            hrsp_pkg::to_lower(c) ==
                                            hrsp_pkg::length_char(pidx_reg[3:0]))
                                        begin
                                            pidx_next  = pidx_reg + 5'd1;
                                            phase_next = hrsp_pkg::H_PREFIX;
                                            if (pidx_next == hrsp_pkg::LENGTH_PREFIX_LEN)
                                            begin
                                                phase_next = hrsp_pkg::H_VAL_WS;
                                                len_next   = '0;
                                            end
                                        end
                                        else
                                        begin
                                            phase_next = hrsp_pkg::H_OTHER;
                                        end
                                    end
                                    hrsp_pkg::H_VAL_WS:
                                    begin
                                        if (c == "0")
                                        begin
                                            phase_next = hrsp_pkg::H_ZERO;
                                        end
                                        else if (c inside {["1":"9"]})
                                        begin
                                            phase_next = hrsp_pkg::H_VAL;
                                            base_next  = hrsp_pkg::BASE_DEC;
                                            len_next   = hrsp_pkg::LENGTH_BITS'(dv[3:0]);
                                        end
                                        else if (!hrsp_pkg::is_space(c))
                                        begin
                                            phase_next = hrsp_pkg::H_VAL_END;
                                        end
                                    end
                                    hrsp_pkg::H_ZERO:
                                    begin
                                        if (c == "x" || c == "X")
                                        begin
                                            phase_next = hrsp_pkg::H_HEX1;
                                        end
                                        else if (c inside {["0":"7"]})
                                        begin
                                            phase_next = hrsp_pkg::H_VAL;
                                            base_next  = hrsp_pkg::BASE_OCT;
                                            len_next   = hrsp_pkg::LENGTH_BITS'(dv[3:0]);
                                        end
                                        else
                                        begin
                                            phase_next = hrsp_pkg::H_VAL_END;
                                        end
                                    end
                                    hrsp_pkg::H_HEX1:
                                    begin
                                        if (dv != hrsp_pkg::DIGIT_NONE)
                                        begin
                                            phase_next = hrsp_pkg::H_VAL;
                                            base_next  = hrsp_pkg::BASE_HEX;
                                            len_next   = hrsp_pkg::LENGTH_BITS'(dv[3:0]);
                                        end
                                        else
                                        begin
                                            phase_next = hrsp_pkg::H_VAL_END;
                                        end
                                    end
                                    hrsp_pkg::H_VAL:
                                    begin
                                        if (dv < hrsp_pkg::radix_of(base_reg))
                                        begin
                                            len_next = hrsp_pkg::mac_len(len_reg, base_reg,
                                                                         dv[3:0]);
                                        end
                                        else
                                        begin
                                            phase_next = hrsp_pkg::H_VAL_END;
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                        end
                    end
                    else if (mode_reg == hrsp_pkg::M_BODY)
                    begin
                        body_valid = 1'b1;
                        if (cnt_reg != hrsp_pkg::LEN_MAX)
                        begin
                            cnt_next = cnt_reg + hrsp_pkg::LENGTH_BITS'(1);
                        end
                        if (seen_reg && cnt_next >= clen_reg)
                        begin
                            mode_next = hrsp_pkg::M_IDLE;
                            done      = 1'b1;
                        end
                    end
                end
                hrsp_pkg::ACT_EOF:
                begin
                    if (mode_reg == hrsp_pkg::M_IDLE || mode_reg == hrsp_pkg::M_CLOSED ||
                        (mode_reg == hrsp_pkg::M_BODY && !seen_reg))
                    begin
                        mode_next = hrsp_pkg::M_CLOSED;
                    end
                    else
                    begin
                        mode_next = hrsp_pkg::M_BROKEN;
                    end
                end
                hrsp_pkg::ACT_NEW:
                begin
                    mode_next  = hrsp_pkg::M_WAIT;
                    phase_next = hrsp_pkg::S_PREFIX;
                    pidx_next  = '0;
                    cr_next    = 1'b0;
                    stat_next  = '0;
                    len_next   = '0;
                    base_next  = hrsp_pkg::BASE_DEC;
                    seen_next  = 1'b0;
                    cnt_next   = '0;
                    clen_next  = '0;
                    sok_next   = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= hrsp_pkg::M_IDLE;
            phase_reg <= hrsp_pkg::S_PREFIX;
            pidx_reg  <= '0;
            cr_reg    <= 1'b0;
            stat_reg  <= '0;
            len_reg   <= '0;
            base_reg  <= hrsp_pkg::BASE_DEC;
            seen_reg  <= 1'b0;
            cnt_reg   <= '0;
            clen_reg  <= '0;
            sok_reg   <= 1'b0;
        end
        else
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            pidx_reg  <= pidx_next;
            cr_reg    <= cr_next;
            stat_reg  <= stat_next;
            len_reg   <= len_next;
            base_reg  <= base_next;
            seen_reg  <= seen_next;
            cnt_reg   <= cnt_next;
            clen_reg  <= clen_next;
            sok_reg   <= sok_next;
        end
    end

    always_comb
    begin
        res                      = '0;
        res.data.parse_state     = mode_next;
        res.data.body_data       = body_valid ? c : 8'd0;
        res.data.status_code     = sok_next ? stat_next : '0;
        res.data.status_valid    = sok_next;
        res.data.content_length  = clen_next;
        res.data.has_length      = seen_next;
        res.data.server_overload = sok_next && (stat_next >= threshold);
        res.body_valid           = body_valid;
        res.response_done        = done;
    end

endmodule
`default_nettype wire

>>> design/hrsp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// hrsp_checker
// Port-level checks on the result stream of the response parser.
// ----------------------------------------------------------------------------
module hrsp_checker
(
    input wire        clk,
    input wire        rst_n,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [63:0] m_tdata,
    input wire [0:0]  m_tuser,
    input wire        m_tlast
);

    hrsp_pkg::tdata_t td;

    assign td = m_tdata;

    // Hold a stalled word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result word changed");

    // A body byte only comes out while in the body or as the closing byte
    a_body_mode: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> td.parse_state == hrsp_pkg::M_BODY ||
                                   td.parse_state == hrsp_pkg::M_IDLE)
        else $error("body byte outside the body");

    // Completion returns the parser to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> td.parse_state == hrsp_pkg::M_IDLE)
        else $error("response completed without going idle");

    // Overload needs an accepted status
    a_overload: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && td.server_overload |-> td.status_valid)
        else $error("overload flag without a status");

endmodule

bind http_response_stream_parser hrsp_checker u_hrsp_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
